// ===== hw/rtl/tkpq_pkg.sv =====
package tkpq_pkg;

  localparam int DEPTH        = 16;
  localparam int TIME_BITS    = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]              cls;
    logic [TIME_BITS-1:0]    tm;
    logic [PAYLOAD_BITS-1:0] pl;
  } entry_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/tkpq_cell.sv =====
module tkpq_cell (
  input  logic                clk,
  input  tkpq_pkg::cell_ctl_t ctl,
  input  logic                occupied,
  input  logic                left_ahead,
  input  tkpq_pkg::entry_t    left_data,
  input  tkpq_pkg::entry_t    right_data,
  output logic                ahead,
  output tkpq_pkg::entry_t    data
);

  // New entry sorts ahead of this one on a strictly smaller key; an empty
  // cell always counts as behind the new entry.
  assign ahead = !occupied ||
                 ({ctl.entry.cls, ctl.entry.tm} < {data.cls, data.tm});

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ahead) begin
        data <= left_ahead ? left_data : ctl.entry;
      end
    end else if (ctl.rem) begin
      data <= right_data;
    end
  end

endmodule

// ===== hw/rtl/two_key_priority_queue.sv =====
// Two-key priority queue: up to tkpq_pkg::DEPTH entries held sorted by
// class, then creation time; equal keys leave in arrival order.
// Input channel (in_valid/in_stall) carries one operation per transfer:
// opcode insert places the entry at its sorted slot, remove returns the
// head entry. Each operation yields exactly one result on the output
// channel (out_valid/out_stall) with status, the removed entry (zero
// unless a remove succeeded) and the count held afterwards.
// The store is a row of cells, one per slot; all cells compare the new
// key in parallel and shift right (insert) or left (remove) in the same
// cycle, and the result is registered and appears in the cycle after its
// input transfer. One operation per cycle is sustained while the receiver
// takes results.
// A remove on an empty queue reports empty; an insert on a full queue is
// dropped and reports full. Neither changes the queue.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// While the receiver stalls, the result register holds and in_stall is
// raised, so no new operation is taken until the result is transferred.
module two_key_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  user_class,
  input  logic [31:0] created_time,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  out_class,
  output logic [31:0] out_time,
  output logic [31:0] out_payload,
  output logic [4:0]  entry_count
);

  localparam int N = tkpq_pkg::DEPTH;

  logic [tkpq_pkg::CNT_W-1:0] count;
  logic [tkpq_pkg::CNT_W-1:0] count_next;
  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  tkpq_pkg::cell_ctl_t        ctl;
  tkpq_pkg::status_t          st_next;
  tkpq_pkg::status_t          st_q;
  tkpq_pkg::entry_t           head_next;
  tkpq_pkg::entry_t           head_q;
  tkpq_pkg::entry_t           cell_data [N];
  logic                       cell_ahead [N];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count == tkpq_pkg::CNT_W'(N));
  assign is_empty = (count == '0);

  always_comb begin
    ctl.entry.cls = user_class;
    ctl.entry.tm  = tkpq_pkg::TIME_BITS'(created_time);
    ctl.entry.pl  = tkpq_pkg::PAYLOAD_BITS'(payload);
    ctl.ins       = 1'b0;
    ctl.rem       = 1'b0;
    st_next       = tkpq_pkg::ST_OK;
    head_next     = '0;
    count_next    = count;
    if (tkpq_pkg::opcode_t'(opcode) == tkpq_pkg::OP_INSERT) begin
      if (is_full) begin
        st_next = tkpq_pkg::ST_FULL;
      end else begin
        ctl.ins    = accept;
        count_next = count + 1'b1;
      end
    end else begin
      if (is_empty) begin
        st_next = tkpq_pkg::ST_EMPTY;
      end else begin
        ctl.rem    = accept;
        head_next  = cell_data[0];
        count_next = count - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic             left_ahead;
    tkpq_pkg::entry_t left_data;
    tkpq_pkg::entry_t right_data;

    if (i == 0) begin : g_first
      assign left_ahead = 1'b0;
      assign left_data  = '0;
    end else begin : g_mid
      assign left_ahead = cell_ahead[i-1];
      assign left_data  = cell_data[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_rest
      assign right_data = cell_data[i+1];
    end

    tkpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (tkpq_pkg::CNT_W'(i) < count),
      .left_ahead (left_ahead),
      .left_data  (left_data),
      .right_data (right_data),
      .ahead      (cell_ahead[i]),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_q        <= st_next;
      head_q      <= head_next;
      entry_count <= 5'(count_next);
    end
  end

  assign status      = st_q;
  assign out_class   = head_q.cls;
  assign out_time    = 32'(head_q.tm);
  assign out_payload = 32'(head_q.pl);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tkpq_pkg::CNT_W'(N))
    else $error("held count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tkpq_pkg::ST_FULL |-> entry_count == 5'(N))
    else $error("full status with queue not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tkpq_pkg::ST_EMPTY |-> entry_count == '0)
    else $error("empty status with entries held");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == tkpq_pkg::OP_REMOVE && !is_empty
    |=> count == $past(count) - 1'b1)
    else $error("remove did not drop count");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    tkpq_pkg::status_t          st;
    tkpq_pkg::entry_t           ent;
    logic [tkpq_pkg::CNT_W-1:0] cnt;
  } op_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [1:0]  user_class;
  logic [31:0] created_time;
  logic [31:0] payload;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [1:0]  out_class;
  logic [31:0] out_time;
  logic [31:0] out_payload;
  logic [4:0]  entry_count;

  tkpq_pkg::entry_t sorted_entries[$];   // predicted contents, head first
  op_result_t       pending_results[$];
  int               errors;
  int               cycle_count;
  int               stall_left;
  bit               idle_on;

  two_key_priority_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .user_class  (user_class),
    .created_time(created_time),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_class   (out_class),
    .out_time    (out_time),
    .out_payload (out_payload),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one operation to the predicted queue and returns its outcome
  function automatic op_result_t apply_op(tkpq_pkg::opcode_t op, tkpq_pkg::entry_t e);
    op_result_t r;
    int         pos;
    r    = '0;
    r.st = tkpq_pkg::ST_OK;
    if (op == tkpq_pkg::OP_INSERT) begin
      if (sorted_entries.size() >= tkpq_pkg::DEPTH) begin
        r.st = tkpq_pkg::ST_FULL;
      end else begin
        // equal keys: new entry goes behind those already held
        pos = 0;
        while (pos < sorted_entries.size() &&
               (e.cls > sorted_entries[pos].cls ||
                (e.cls == sorted_entries[pos].cls && e.tm >= sorted_entries[pos].tm)))
          pos++;
        sorted_entries.insert(pos, e);
      end
    end else if (sorted_entries.size() == 0) begin
      r.st = tkpq_pkg::ST_EMPTY;
    end else begin
      r.ent = sorted_entries.pop_front();
    end
    r.cnt = tkpq_pkg::CNT_W'(sorted_entries.size());
    return r;
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 3);   // narrow range, plenty of ties
      1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Called just after a rising edge; returns at the edge of the transfer
  task automatic send_op(tkpq_pkg::opcode_t op, logic [1:0] cls, logic [31:0] tm,
                         logic [31:0] pl);
    tkpq_pkg::entry_t e;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    user_class   <= cls;
    created_time <= tm;
    payload      <= pl;
    do @(posedge clk); while (in_stall);
    e.cls = cls;
    e.tm  = tm;
    e.pl  = pl;
    pending_results.push_back(apply_op(op, e));
  endtask

  task automatic random_op(int insert_pct);
    tkpq_pkg::opcode_t op;
    op = ($urandom_range(0, 99) < insert_pct) ? tkpq_pkg::OP_INSERT : tkpq_pkg::OP_REMOVE;
    send_op(op, 2'($urandom_range(0, 3)), pick_time(), $urandom());
  endtask

  task automatic test_remove_on_empty();
    idle_on = 1'b1;
    send_op(tkpq_pkg::OP_REMOVE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Sixteen inserts covering key extremes and ties, then one on a full queue
  task automatic test_fill_to_full();
    send_op(tkpq_pkg::OP_INSERT, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(tkpq_pkg::OP_INSERT, 2'd0, 32'h0000_0000, 32'h0000_0000);
    send_op(tkpq_pkg::OP_INSERT, 2'd1, 32'd100,       32'h0000_0001);
    send_op(tkpq_pkg::OP_INSERT, 2'd1, 32'd100,       32'h0000_0002);
    send_op(tkpq_pkg::OP_INSERT, 2'd1, 32'd50,        32'h0000_0003);
    send_op(tkpq_pkg::OP_INSERT, 2'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_op(tkpq_pkg::OP_INSERT, 2'd3, 32'h0000_0000, 32'h5A5A_5A5A);
    send_op(tkpq_pkg::OP_INSERT, 2'd2, 32'd7,         32'h0000_0004);
    send_op(tkpq_pkg::OP_INSERT, 2'd2, 32'd7,         32'h0000_0005);
    send_op(tkpq_pkg::OP_INSERT, 2'd2, 32'd7,         32'h0000_0006);
    send_op(tkpq_pkg::OP_INSERT, 2'd1, 32'd100,       32'h0000_0007);
    send_op(tkpq_pkg::OP_INSERT, 2'd0, 32'h0000_0000, 32'h8000_0000);
    send_op(tkpq_pkg::OP_INSERT, 2'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_op(tkpq_pkg::OP_INSERT, 2'd2, 32'd8,         32'h0000_0008);
    send_op(tkpq_pkg::OP_INSERT, 2'd1, 32'd99,        32'h0000_0009);
    send_op(tkpq_pkg::OP_INSERT, 2'd0, 32'd1,         32'h0000_000A);
    // smallest possible key, still rejected
    send_op(tkpq_pkg::OP_INSERT, 2'd0, 32'h0000_0000, 32'hDEAD_0000);
  endtask

  task automatic test_head_removal();
    repeat (5) send_op(tkpq_pkg::OP_REMOVE, 2'($urandom_range(0, 3)), $urandom(), $urandom());
  endtask

  task automatic test_random_mixed(int n);
    idle_on = 1'b1;
    repeat (n) random_op(50);
  endtask

  // Fill to a level (mostly full and beyond), then drain (mostly to empty and beyond)
  task automatic test_fill_drain(int rounds);
    int level;
    idle_on = 1'b1;
    repeat (rounds) begin
      level = ($urandom_range(0, 2) == 0) ? $urandom_range(1, tkpq_pkg::DEPTH)
                                          : tkpq_pkg::DEPTH;
      while (sorted_entries.size() < level) random_op(100);
      if (level == tkpq_pkg::DEPTH) repeat ($urandom_range(1, 3)) random_op(100);
      level = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tkpq_pkg::DEPTH / 2) : 0;
      while (sorted_entries.size() > level) random_op(0);
      if (level == 0) repeat ($urandom_range(1, 2)) random_op(0);
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    repeat (n) random_op(sorted_entries.size() < tkpq_pkg::DEPTH / 2 ? 65 : 35);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    op_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: status %0d count %0d", $time, status, entry_count);
      end else begin
        want = pending_results.pop_front();
        check_field("status",      want.st,     status);
        check_field("out_class",   want.ent.cls, out_class);
        check_field("out_time",    want.ent.tm,  out_time);
        check_field("out_payload", want.ent.pl,  out_payload);
        check_field("entry_count", want.cnt,    entry_count);
      end
    end
  end

  // Receiver stall in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = tkpq_pkg::OP_INSERT;
    user_class   = '0;
    created_time = '0;
    payload      = '0;
    out_stall    = 1'b0;
    errors       = 0;
    idle_on      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_remove_on_empty();
    test_fill_to_full();
    test_head_removal();
    test_random_mixed(600);
    test_fill_drain(20);
    test_back_to_back(500);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
